// File: src/first_fit_block_allocator_macros.svh
// Assertion macros used by the checker file.
// No dependencies; the includer supplies clock and reset names.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Holds at every edge outside reset.
`define FBAL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent now, consequent in the next cycle.
`define FBAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/fbal_pkg.sv
// Package for the first-fit block allocator: block codes, modes, status
// codes, sequencer states and default sizes. No dependencies.
`default_nettype none
package fbal_pkg;

  localparam int NUM_BLOCKS_DEF = 256;

  localparam logic [1:0] CODE_FREE = 2'd0;
  localparam logic [1:0] CODE_USED = 2'd1;
  localparam logic [1:0] CODE_LAST = 2'd3;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_RESIZE  = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ALLOC,
    S_FIND_RD,
    S_FIND_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_HINT_RD,
    S_HINT_EV,
    S_FREE_RD,
    S_FREE_WR,
    S_MEAS_RD,
    S_MEAS_EV,
    S_TERM,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/first_fit_block_allocator.sv
// First-fit block allocator top level: block map memory and its sequencer.
// Depends on fbal_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start high, busy low | mode, block_index, block_count
//  result   | done, one cycle      | status, result_index, old_length,
//           |                      | blocks_in_use
//
// Sequencing: every map access is a read state then an evaluate/write state
// on the block map (one read port, one write port). Allocate scans from the
// hint, marks the run and rescans for the hint; resize measures and then
// keeps, trims, or reallocates and releases.
// Reset: a clearing pass writes every block free with busy high. The
// receiver cannot stall; done lasts exactly one cycle.
`default_nettype none
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = fbal_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] block_index,
  input  wire logic [8:0] block_count,
  output logic            done,
  output logic [1:0]      status,
  output logic [8:0]      result_index,
  output logic [8:0]      old_length,
  output logic [8:0]      blocks_in_use
);
  import fbal_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int IW = (CW > 9) ? CW : 9;   // pointers, counts and "none"
  localparam logic [IW-1:0] NONE = IW'(NUM_BLOCKS);
  localparam logic [IW-1:0] ONE  = IW'(1);

  // block map, one 2-bit code per block
  logic [1:0] map_mem [NUM_BLOCKS];
  logic [1:0] rdata;
  logic       we;
  logic [AW-1:0] waddr;
  logic [1:0] wdata;

  state_t state, state_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [IW-1:0] run, run_next;           // free blocks seen in a row
  logic [IW-1:0] run_head, run_head_next; // head of run being found/marked
  logic [IW-1:0] cnt, cnt_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] hint, hint_next;
  logic [IW-1:0] used, used_next;
  logic [IW-1:0] len, len_next;
  logic [IW-1:0] result, result_next;
  logic          bad, bad_next;
  logic          oom, oom_next;
  logic          is_resize, is_resize_next;
  logic          trim, trim_next;

  logic [IW-1:0] ptr_inc, idx_in, cnt_in, len_inc, tail_last;
  logic          at_end, run_end;

  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    rdata <= map_mem[ptr[AW-1:0]];
  end

  assign ptr_inc   = ptr + ONE;
  assign at_end    = (ptr_inc >= NONE);
  assign idx_in    = IW'(block_index);
  assign cnt_in    = IW'(block_count);
  assign len_inc   = len + ONE;
  assign tail_last = run_head + cnt - ONE;
  assign run_end   = (ptr == tail_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ptr   <= '0;
      hint  <= '0;
      used  <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      hint  <= hint_next;
      used  <= used_next;
    end
    run       <= run_next;
    run_head  <= run_head_next;
    cnt       <= cnt_next;
    idx       <= idx_next;
    len       <= len_next;
    result    <= result_next;
    bad       <= bad_next;
    oom       <= oom_next;
    is_resize <= is_resize_next;
    trim      <= trim_next;
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    run_next       = run;
    run_head_next  = run_head;
    cnt_next       = cnt;
    idx_next       = idx;
    hint_next      = hint;
    used_next      = used;
    len_next       = len;
    result_next    = result;
    bad_next       = bad;
    oom_next       = oom;
    is_resize_next = is_resize;
    trim_next      = trim;
    we             = 1'b0;
    waddr          = ptr[AW-1:0];
    wdata          = CODE_FREE;

    case (state)
      S_CLR: begin
        we = 1'b1;
        ptr_next = ptr_inc;
        if (at_end) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          idx_next       = idx_in;
          cnt_next       = cnt_in;
          result_next    = NONE;
          len_next       = '0;
          bad_next       = 1'b0;
          oom_next       = 1'b0;
          trim_next      = 1'b0;
          is_resize_next = (mode == MODE_RESIZE);
          ptr_next       = idx_in;
          case (mode)
            MODE_ALLOC: begin
              state_next = (cnt_in == '0) ? S_DONE : S_ALLOC;
            end
            MODE_RELEASE, MODE_RESIZE: begin
              if (idx_in >= NONE) begin
                bad_next   = 1'b1;
                state_next = S_DONE;
              end else if (mode == MODE_RELEASE || cnt_in == '0) begin
                is_resize_next = 1'b0;
                state_next     = S_FREE_RD;
              end else begin
                state_next = S_MEAS_RD;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_ALLOC: begin
        if (hint >= NONE) begin
          oom_next    = 1'b1;
          result_next = NONE;
          if (is_resize) begin
            ptr_next   = idx;
            state_next = S_FREE_RD;
          end else begin
            state_next = S_DONE;
          end
        end else if (cnt > ONE) begin
          ptr_next   = hint;
          run_next   = '0;
          state_next = S_FIND_RD;
        end else begin
          ptr_next      = hint;
          run_head_next = hint;
          state_next    = S_MARK_RD;
        end
      end

      S_FIND_RD: state_next = S_FIND_EV;

      S_FIND_EV: begin
        if (rdata == CODE_FREE) begin
          run_next = run + ONE;
          if (run == '0) begin
            run_head_next = ptr;
          end
          if (run + ONE >= cnt) begin
            ptr_next      = (run == '0) ? ptr : run_head;
            run_head_next = (run == '0) ? ptr : run_head;
            state_next    = S_MARK_RD;
          end
        end else begin
          run_next = '0;
        end
        if (!(rdata == CODE_FREE && run + ONE >= cnt)) begin
          ptr_next = ptr_inc;
          if (at_end) begin
            oom_next    = 1'b1;
            result_next = NONE;
            if (is_resize) begin
              ptr_next   = idx;
              state_next = S_FREE_RD;
            end else begin
              state_next = S_DONE;
            end
          end else begin
            state_next = S_FIND_RD;
          end
        end
      end

      S_MARK_RD: state_next = S_MARK_WR;

      S_MARK_WR: begin
        we    = 1'b1;
        wdata = run_end ? CODE_LAST : CODE_USED;
        if (rdata == CODE_FREE) begin
          used_next = used + ONE;
        end
        ptr_next = ptr_inc;
        if (!run_end) begin
          state_next = S_MARK_RD;
        end else begin
          result_next = run_head;
          if (hint >= run_head && !at_end) begin
            state_next = S_HINT_RD;
          end else begin
            if (hint >= run_head) begin
              hint_next = NONE;
            end
            if (is_resize) begin
              ptr_next   = idx;
              state_next = S_FREE_RD;
            end else begin
              state_next = S_DONE;
            end
          end
        end
      end

      S_HINT_RD: state_next = S_HINT_EV;

      S_HINT_EV: begin
        if (rdata == CODE_FREE || at_end) begin
          hint_next = (rdata == CODE_FREE) ? ptr : NONE;
          if (is_resize) begin
            ptr_next   = idx;
            state_next = S_FREE_RD;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_HINT_RD;
        end
      end

      S_FREE_RD: state_next = S_FREE_WR;

      S_FREE_WR: begin
        we = 1'b1;
        if (rdata != CODE_FREE && used != '0) begin
          used_next = used - ONE;
        end
        if (rdata == CODE_FREE) begin
          bad_next = 1'b1;
        end
        if (rdata == CODE_LAST || at_end) begin
          if (rdata != CODE_LAST) begin
            bad_next = 1'b1;   // ran off the map without a terminator
          end
          if (trim) begin
            state_next = S_TERM;
          end else begin
            if (hint > idx) begin
              hint_next = idx;
            end
            state_next = S_DONE;
          end
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_FREE_RD;
        end
      end

      S_TERM: begin
        // new terminator one before the freed tail
        we    = 1'b1;
        waddr = tail_last[AW-1:0];
        wdata = CODE_LAST;
        if (hint > tail_last + ONE) begin
          hint_next = tail_last + ONE;
        end
        state_next = S_DONE;
      end

      S_MEAS_RD: state_next = S_MEAS_EV;

      S_MEAS_EV: begin
        if (rdata == CODE_FREE) begin
          bad_next = 1'b1;
        end
        len_next = len_inc;
        if (rdata == CODE_LAST || at_end) begin
          if (rdata != CODE_LAST) begin
            bad_next = 1'b1;
          end
          if (len_inc == cnt) begin
            result_next = idx;
            state_next  = S_DONE;
          end else if (len_inc > cnt) begin
            result_next   = idx;
            run_head_next = idx;       // tail_last = idx + cnt - 1
            ptr_next      = idx + cnt;
            trim_next     = 1'b1;
            state_next    = S_FREE_RD;
          end else begin
            state_next = S_ALLOC;
          end
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_MEAS_RD;
        end
      end

      S_DONE: state_next = S_IDLE;

      default: state_next = S_IDLE;
    endcase
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign status        = bad ? ST_BAD : (oom ? ST_OOM : ST_OK);
  assign result_index  = result[8:0];
  assign old_length    = len[8:0];
  assign blocks_in_use = used[8:0];

endmodule
`default_nettype wire

// File: src/fbal_checker.sv
// Port-level checker for the first-fit block allocator, with its bind.
// Depends on fbal_pkg and first_fit_block_allocator_macros.svh.
`default_nettype none
`include "first_fit_block_allocator_macros.svh"
module fbal_checker #(
  parameter int NUM_BLOCKS = fbal_pkg::NUM_BLOCKS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [8:0] result_index
);
  import fbal_pkg::*;

  localparam logic [8:0] NONE9 = 9'(NUM_BLOCKS);

  `FBAL_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done longer than one cycle")
  `FBAL_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy, "accepted but not busy")
  `FBAL_ASSERT(a_done_busy, clk, rst, !done || busy, "result while idle")
  `FBAL_ASSERT(a_status_code, clk, rst, !done || status != 2'd3, "undefined status")
  `FBAL_ASSERT(a_oom_none, clk, rst, !(done && status == ST_OOM) || result_index == NONE9,
               "out of memory with a run index")
endmodule

bind first_fit_block_allocator fbal_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_fbal_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .result_index(result_index)
);
`default_nettype wire

// File: dv/tb_first_fit_block_allocator.sv
// Self-checking testbench for first_fit_block_allocator: directed table, then
// random allocate/release/resize traffic checked against a behavioral map.
// Depends on fbal_pkg and the first_fit_block_allocator RTL.
`default_nettype none
module tb_first_fit_block_allocator;
  import fbal_pkg::*;

  localparam int NB = NUM_BLOCKS_DEF;
  localparam logic [8:0] NONE = 9'(NB);
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = MODE_ALLOC;
  logic [7:0] block_index = '0;
  logic [8:0] block_count = '0;
  logic done;
  logic [1:0] status;
  logic [8:0] result_index, old_length, blocks_in_use;

  always #6 clk = ~clk;

  first_fit_block_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .block_index(block_index), .block_count(block_count), .done(done),
    .status(status), .result_index(result_index), .old_length(old_length),
    .blocks_in_use(blocks_in_use)
  );

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] result_index;
    logic [8:0] old_length;
    logic [8:0] blocks_in_use;
  } outcome_t;

  // Behavioral copy of the block map and its bookkeeping.
  logic [1:0] blk_code [NB];
  int hint, in_use;
  bit bad_seen;
  outcome_t pending_outcomes[$];
  int n_errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  bit timed_out = 1'b0;
  bit seen_oom = 1'b0, seen_bad_status = 1'b0;

  function automatic void free_to_term(int first);
    logic [1:0] s;
    for (int b = first; b < NB; b++) begin
      s = blk_code[b];
      blk_code[b] = CODE_FREE;
      if (s != CODE_FREE && in_use > 0) in_use--;
      if (s == CODE_LAST) return;
      if (s == CODE_FREE) bad_seen = 1'b1;
    end
    bad_seen = 1'b1;
  endfunction

  function automatic void release_at(int first);
    free_to_term(first);
    if (hint > first) hint = first;
  endfunction

  function automatic int first_fit(int n);
    int head, b, run;
    head = hint;
    if (head >= NB) return NB;
    if (n > 1) begin
      run = 0;
      head = NB;
      for (b = hint; b < NB; b++) begin
        if (blk_code[b] == CODE_FREE) begin
          if (run == 0) head = b;
          run++;
          if (run >= n) break;
        end else begin
          run = 0;
        end
      end
      if (run < n) head = NB;
    end
    if (head >= NB) return NB;
    // mark the run, then move the hint past it if it was in the way
    for (int i = 0; i < n; i++) begin
      if (blk_code[head+i] == CODE_FREE) in_use++;
      blk_code[head+i] = (i + 1 == n) ? CODE_LAST : CODE_USED;
    end
    if (hint >= head) begin
      for (b = head + n; b < NB; b++)
        if (blk_code[b] == CODE_FREE) break;
      hint = b;
    end
    return head;
  endfunction

  function automatic int run_length(int first);
    int len;
    len = 0;
    for (int b = first; b < NB; b++) begin
      if (blk_code[b] == CODE_FREE) bad_seen = 1'b1;
      len++;
      if (blk_code[b] == CODE_LAST) return len;
    end
    bad_seen = 1'b1;
    return len;
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] m, int idx, int cnt);
    outcome_t o;
    int res, olen, tail;
    bit oom;
    res = NB;
    olen = 0;
    oom = 1'b0;
    bad_seen = 1'b0;
    if (m == MODE_ALLOC) begin
      if (cnt != 0) begin
        res = first_fit(cnt);
        oom = (res >= NB);
      end
    end else if (m == MODE_RELEASE || m == MODE_RESIZE) begin
      if (m == MODE_RELEASE || cnt == 0) begin
        release_at(idx);
      end else begin
        olen = run_length(idx);
        if (olen == cnt) begin
          res = idx;
        end else if (olen > cnt) begin
          // trim: free the tail, re-terminate, pull the hint down
          tail = idx + cnt;
          free_to_term(tail);
          blk_code[tail-1] = CODE_LAST;
          if (hint > tail) hint = tail;
          res = idx;
        end else begin
          // grow: new run first, old run released even if that failed
          res = first_fit(cnt);
          oom = (res >= NB);
          release_at(idx);
        end
      end
    end
    o.status = bad_seen ? ST_BAD : (oom ? ST_OOM : ST_OK);
    o.result_index = 9'(res);
    o.old_length = 9'(olen);
    o.blocks_in_use = 9'(in_use);
    return o;
  endfunction

  // Drive one transaction at the falling edge, hold until accepted.
  // start stays high on return; drain, or a gap in the next issue, takes it down.
  task automatic issue(logic [1:0] m, logic [7:0] idx, logic [8:0] cnt);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    mode <= m;
    block_index <= idx;
    block_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(m, idx, cnt));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // Result checker: done is a single-cycle strobe, sampled at posedge.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && start && !busy) n_accepted++;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (status == ST_OOM) seen_oom = 1'b1;
        if (status == ST_BAD) seen_bad_status = 1'b1;
        if (status !== want.status) begin
          $error("status exp %0d got %0d", want.status, status);
          n_errors++;
        end
        if (result_index !== want.result_index) begin
          $error("result_index exp %0d got %0d", want.result_index, result_index);
          n_errors++;
        end
        if (old_length !== want.old_length) begin
          $error("old_length exp %0d got %0d", want.old_length, old_length);
          n_errors++;
        end
        if (blocks_in_use !== want.blocks_in_use) begin
          $error("blocks_in_use exp %0d got %0d", want.blocks_in_use, blocks_in_use);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with neither a command nor a result accepted.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_first_fit_block_allocator: FAIL");
      $finish;
    end
  end

  // Directed rows; typed outcomes only where obvious, else predictor only.
  typedef struct {
    logic [1:0] m;
    logic [7:0] idx;
    logic [8:0] cnt;
    bit typed;
    outcome_t want;
  } row_t;

  row_t rows[$];
  int live_heads[$];

  function automatic void add_row(logic [1:0] m, logic [7:0] idx, logic [8:0] cnt,
                                  bit typed = 0, logic [1:0] st = ST_OK,
                                  logic [8:0] ri = NONE, logic [8:0] ol = 0,
                                  logic [8:0] bu = 0);
    row_t r;
    r.m = m; r.idx = idx; r.cnt = cnt; r.typed = typed;
    r.want = '{st, ri, ol, bu};
    rows.push_back(r);
  endfunction

  initial begin
    outcome_t got;
    int pick, k, w, cnt;
    logic [1:0] m;

    // fresh map
    add_row(MODE_ALLOC, 8'd0, 9'd0, 1, ST_OK, NONE, 0, 0);         // zero count
    add_row(2'd3, 8'hFF, 9'h1FF, 1, ST_OK, NONE, 0, 0);            // mode three
    add_row(MODE_RELEASE, 8'd5, 9'd0, 1, ST_BAD, NONE, 0, 0);      // free block, no term
    add_row(MODE_RESIZE, 8'd7, 9'd249, 1, ST_BAD, 9'd7, 9'd249, 0); // measure free: same, bad
    add_row(MODE_ALLOC, 8'd0, 9'd257, 1, ST_OOM, NONE, 0, 0);      // too large
    add_row(MODE_ALLOC, 8'd0, 9'd256, 1, ST_OK, 9'd0, 0, 9'd256);  // whole map
    add_row(MODE_ALLOC, 8'd0, 9'd1, 1, ST_OOM, NONE, 0, 9'd256);   // full
    add_row(MODE_RESIZE, 8'd0, 9'd256, 1, ST_OK, 9'd0, 9'd256, 9'd256);
    add_row(MODE_RESIZE, 8'd0, 9'd10, 1, ST_OK, 9'd0, 9'd256, 9'd10); // trim
    add_row(MODE_ALLOC, 8'd0, 9'd5, 0);
    add_row(MODE_ALLOC, 8'd0, 9'd1, 0);
    add_row(MODE_RESIZE, 8'd10, 9'd8, 0);                          // grow, relocate
    add_row(MODE_RESIZE, 8'd0, 9'd0, 0);                           // resize zero
    add_row(MODE_RELEASE, 8'd0, 9'd0, 0);                          // double release
    add_row(MODE_RESIZE, 8'd15, 9'd200, 0);                        // grow, may fail
    add_row(MODE_RELEASE, 8'd255, 9'h1FF, 0);
    add_row(MODE_ALLOC, 8'hAA, 9'd255, 0);
    add_row(MODE_RESIZE, 8'd1, 9'h155, 0);
    add_row(MODE_RELEASE, 8'h55, 9'h0AA, 0);
    add_row(MODE_RELEASE, 8'd0, 9'd0, 0);

    for (int i = 0; i < NB; i++) blk_code[i] = CODE_FREE;
    hint = 0;
    in_use = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      issue(rows[i].m, rows[i].idx, rows[i].cnt);
      if (rows[i].typed && pending_outcomes[$] != rows[i].want) begin
        got = pending_outcomes[$];
        $error("row %0d table/predictor disagree: %h vs %h", i, rows[i].want, got);
        n_errors++;
      end
    end
    drain(); // sender holds off until every result is back

    // Random part: allocations and operations on live runs, some noise.
    for (int n = 0; n < N_RANDOM; n++) begin
      case ((n * 4) / N_RANDOM)
        0: send_gap_pct = 0;
        1: send_gap_pct = 57;
        2: send_gap_pct = 31;
        default: send_gap_pct = (n % 100 < 50) ? 0 : 57;
      endcase
      // keep the live list in step with the model map
      for (int j = live_heads.size() - 1; j >= 0; j--)
        if (blk_code[live_heads[j]] == CODE_FREE) live_heads.delete(j);
      pick = $urandom_range(99);
      if (pick < 45 || live_heads.size() == 0) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
        issue(MODE_ALLOC, 8'($urandom), 9'(cnt));
        got = pending_outcomes[$];
        if (got.result_index != NONE) live_heads.push_back(got.result_index);
      end else if (pick < 90) begin
        k = $urandom_range(live_heads.size() - 1);
        w = live_heads[k];
        m = ($urandom_range(1)) ? MODE_RELEASE : MODE_RESIZE;
        cnt = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 30);
        issue(m, 8'(w), 9'(cnt));
        got = pending_outcomes[$];
        if (m == MODE_RESIZE && got.result_index != NONE && got.result_index != w)
          live_heads.push_back(got.result_index);
      end else begin
        issue(2'($urandom), 8'($urandom), 9'($urandom));
      end
      if (n == N_RANDOM / 2) drain();
    end

    drain();
    repeat (2 * NB * 4) @(negedge clk);
    $display("covered %0d commands, %0d results checked; oom seen %0d, bad-map seen %0d",
             n_accepted, n_checked, seen_oom, seen_bad_status);
    if (n_errors == 0 && pending_outcomes.size() == 0) begin
      $display("tb_first_fit_block_allocator: PASS");
    end else begin
      $display("tb_first_fit_block_allocator: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: first_fit_block_allocator.f
+incdir+src
src/fbal_pkg.sv
src/first_fit_block_allocator.sv
src/fbal_checker.sv
dv/tb_first_fit_block_allocator.sv
